// ===== sv/pdd_pkg.sv =====
// Shared types, constants and the control store for the PID differential-drive block.
`default_nettype none
package pdd_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int DUTY_BITS   = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int STEP_W      = 4;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REFERENCE  = 3'd0,
    REG_KP         = 3'd1,
    REG_KI         = 3'd2,
    REG_KD         = 3'd3,
    REG_PERIOD     = 3'd4,
    REG_CRUISE     = 3'd5,
    REG_DUTY_FLOOR = 3'd6,
    REG_DUTY_CEIL  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] left_sample;
    logic [SAMPLE_BITS-1:0] right_sample;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        left_speed;
    logic [15:0]        right_speed;
    logic signed [31:0] control_value;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic [11:0]        reference;
    logic signed [15:0] kp;
    logic signed [15:0] ki;
    logic signed [15:0] kd;
    logic [15:0]        sample_period;
    logic [15:0]        cruise_duty;
    logic [15:0]        duty_floor;
    logic [15:0]        duty_ceil;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_E_PERIOD,
    MUL_KP_E,
    MUL_KI_INT,
    MUL_KD_DER
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_NO_INPUT,
    COND_DIV_BUSY,
    COND_OUT_BUSY
  } cond_e;

  // one microcode word
  typedef struct packed {
    logic     take_in;
    logic     calc_err;
    logic     div_start;
    logic     integ_upd;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     sat_u;
    logic     emit;
    cond_e    cond;
    step_t    target;
    logic     restart;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic div_busy;
    logic out_busy;
  } status_t;

  localparam step_t UC_WAIT     = STEP_W'(0);
  localparam step_t UC_ERR      = STEP_W'(1);
  localparam step_t UC_MUL_EP   = STEP_W'(2);
  localparam step_t UC_INTEG    = STEP_W'(3);
  localparam step_t UC_ACC_KP   = STEP_W'(4);
  localparam step_t UC_ACC_KI   = STEP_W'(5);
  localparam step_t UC_DIV_WAIT = STEP_W'(6);
  localparam step_t UC_MUL_KD   = STEP_W'(7);
  localparam step_t UC_ACC_KD   = STEP_W'(8);
  localparam step_t UC_SAT      = STEP_W'(9);
  localparam step_t UC_EMIT     = STEP_W'(10);

  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t c;
    c = '0;
    case (step)
      UC_WAIT: begin
        c.take_in = 1'b1;
        c.cond    = COND_NO_INPUT;
        c.target  = UC_WAIT;
      end
      UC_ERR: begin
        c.calc_err = 1'b1;
      end
      UC_MUL_EP: begin
        c.mul_sel   = MUL_E_PERIOD;
        c.div_start = 1'b1;
      end
      UC_INTEG: begin
        c.integ_upd = 1'b1;
        c.mul_sel   = MUL_KP_E;
      end
      UC_ACC_KP: begin
        c.acc_op  = ACC_LOAD;
        c.mul_sel = MUL_KI_INT;
      end
      UC_ACC_KI: begin
        c.acc_op = ACC_ADD;
      end
      UC_DIV_WAIT: begin
        c.cond   = COND_DIV_BUSY;
        c.target = UC_DIV_WAIT;
      end
      UC_MUL_KD: begin
        c.mul_sel = MUL_KD_DER;
      end
      UC_ACC_KD: begin
        c.acc_op = ACC_ADD;
      end
      UC_SAT: begin
        c.sat_u = 1'b1;
      end
      UC_EMIT: begin
        c.emit    = 1'b1;
        c.cond    = COND_OUT_BUSY;
        c.target  = UC_EMIT;
        c.restart = 1'b1;
      end
      default: begin
        c.restart = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/pdd_div.sv =====
// Iterative signed divider, two quotient bits per cycle, truncating toward zero.
`default_nettype none
module pdd_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [16:0] dividend_i,
  input  wire logic [15:0]        divisor_i,
  output logic signed [16:0]      quot_o,
  output logic                    busy_o
);

  localparam int QW    = 16;
  localparam int STEPS = QW / 2;
  localparam int CW    = $clog2(STEPS);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          neg_q, neg_d;
  logic [QW-1:0] num_q, num_d;
  logic [QW-1:0] rem_q, rem_d;
  logic [QW-1:0] den_q, den_d;
  logic [16:0]   mag;
  logic [QW-1:0] rem_mid;
  logic          bit_hi, bit_lo;

  // one restoring step: shift in a numerator bit, subtract when it fits
  function automatic logic [QW:0] div_step(input logic [QW-1:0] rem, input logic nb,
                                           input logic [QW-1:0] den);
    logic [QW:0] r;
    r = {rem, nb};
    if (r >= {1'b0, den}) begin
      r = r - {1'b0, den};
      return {r[QW-1:0], 1'b1};
    end
    return {r[QW-1:0], 1'b0};
  endfunction

  assign mag = dividend_i[16] ? 17'(-dividend_i) : 17'(dividend_i);

  always_comb begin
    logic [QW:0] s1;
    logic [QW:0] s2;
    s1      = div_step(rem_q, num_q[QW-1], den_q);
    rem_mid = s1[QW:1];
    bit_hi  = s1[0];
    s2      = div_step(rem_mid, num_q[QW-2], den_q);
    bit_lo  = s2[0];

    busy_d = busy_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = dividend_i[16];
      num_d  = mag[QW-1:0];
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (busy_q) begin
      num_d = {num_q[QW-3:0], bit_hi, bit_lo};
      rem_d = s2[QW:1];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(STEPS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quot_o = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});
  assign busy_o = busy_q;

endmodule
`default_nettype wire

// ===== sv/pdd_ucode.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none
module pdd_ucode (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire pdd_pkg::status_t status_i,
  output pdd_pkg::ctrl_t        ctrl_o,
  output logic                  go_o
);
  import pdd_pkg::*;

  step_t step_q, step_d;
  ctrl_t ctrl;
  logic  hold;

  assign ctrl = ucode_rom(step_q);

  always_comb begin
    case (ctrl.cond)
      COND_NEVER:    hold = 1'b0;
      COND_NO_INPUT: hold = !status_i.in_valid;
      COND_DIV_BUSY: hold = status_i.div_busy;
      COND_OUT_BUSY: hold = status_i.out_busy;
      default:       hold = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      step_d = ctrl.target;
    end else if (ctrl.restart) begin
      step_d = UC_WAIT;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= UC_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = ctrl;
  assign go_o   = !hold;

endmodule
`default_nettype wire

// ===== sv/pdd_datapath.sv =====
// PID datapath: error, shared multiplier, accumulator, saturation, wheel clamps, output register.
`default_nettype none
module pdd_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pdd_pkg::ctrl_t     ctrl_i,
  input  wire logic               go_i,
  input  wire pdd_pkg::cfg_t      cfg_i,
  input  wire pdd_pkg::in_item_t  in_data_i,
  input  wire logic               out_ready_i,
  input  wire logic signed [16:0] div_quot_i,
  output logic signed [16:0]      div_dividend_o,
  output logic [15:0]             period_o,
  output logic                    out_valid_o,
  output pdd_pkg::out_item_t      out_data_o,
  output logic                    out_busy_o
);
  import pdd_pkg::*;

  localparam int EW = 20;

  logic [SAMPLE_BITS-1:0] left_q, right_q;
  logic signed [15:0]     err_q, err_d;
  logic signed [15:0]     last_q;
  logic signed [31:0]     integ_q, integ_d;
  logic signed [49:0]     prod_q, prod_d;
  logic signed [49:0]     acc_q, acc_d;
  logic signed [31:0]     u_q, u_d;
  logic                   hit_q, hit_d;
  logic                   integ_ovf, u_ovf;
  logic                   out_valid_q;
  out_item_t              out_q, out_d;

  logic signed [EW-1:0]   err_wide;
  logic signed [16:0]     mul_a;
  logic signed [32:0]     mul_b;
  logic signed [33:0]     integ_sum;

  assign period_o = (cfg_i.sample_period == '0) ? 16'd1 : cfg_i.sample_period;

  // e = reference - (left - right), held to 16 bits signed
  assign err_wide = $signed(EW'(cfg_i.reference))
                  - ($signed(EW'(left_q)) - $signed(EW'(right_q)));
  always_comb begin
    if (err_wide[EW-1:15] != {(EW - 15){err_wide[EW-1]}}) begin
      err_d = err_wide[EW-1] ? -16'sd32768 : 16'sd32767;
    end else begin
      err_d = err_wide[15:0];
    end
  end

  assign div_dividend_o = $signed({err_q[15], err_q}) - $signed({last_q[15], last_q});

  always_comb begin
    case (ctrl_i.mul_sel)
      MUL_E_PERIOD: begin
        mul_a = {err_q[15], err_q};
        mul_b = $signed({17'b0, period_o});
      end
      MUL_KP_E: begin
        mul_a = {cfg_i.kp[15], cfg_i.kp};
        mul_b = {{17{err_q[15]}}, err_q};
      end
      MUL_KI_INT: begin
        mul_a = {cfg_i.ki[15], cfg_i.ki};
        mul_b = {integ_q[31], integ_q};
      end
      MUL_KD_DER: begin
        mul_a = {cfg_i.kd[15], cfg_i.kd};
        mul_b = {{16{div_quot_i[16]}}, div_quot_i};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  assign integ_sum = $signed({{2{integ_q[31]}}, integ_q}) + $signed(prod_q[33:0]);
  assign integ_ovf = integ_sum[33:31] != {3{integ_sum[33]}};
  always_comb begin
    if (integ_ovf) begin
      integ_d = integ_sum[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      integ_d = integ_sum[31:0];
    end
  end

  always_comb begin
    case (ctrl_i.acc_op)
      ACC_LOAD: acc_d = prod_q;
      ACC_ADD:  acc_d = acc_q + prod_q;
      default:  acc_d = acc_q;
    endcase
  end

  assign u_ovf = acc_q[49:31] != {19{acc_q[49]}};
  always_comb begin
    if (u_ovf) begin
      u_d = acc_q[49] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      u_d = acc_q[31:0];
    end
  end

  always_comb begin
    hit_d = hit_q;
    if (ctrl_i.calc_err) begin
      hit_d = 1'b0;
    end else if (ctrl_i.integ_upd && integ_ovf) begin
      hit_d = 1'b1;
    end else if (ctrl_i.sat_u && u_ovf) begin
      hit_d = 1'b1;
    end
  end

  // lower clamp, then upper, then duty full scale
  function automatic logic [15:0] wheel(input logic signed [33:0] v_in,
                                        input logic [15:0] lo, input logic [15:0] hi);
    logic signed [33:0] v;
    v = v_in;
    if (v < $signed(34'(lo))) v = $signed(34'(lo));
    if (v > $signed(34'(hi))) v = $signed(34'(hi));
    if (v < 34'sd0) v = '0;
    if (v > $signed(34'((35'd1 << DUTY_BITS) - 35'd1))) begin
      v = $signed(34'((35'd1 << DUTY_BITS) - 35'd1));
    end
    return v[15:0];
  endfunction

  always_comb begin
    out_d.left_speed    = wheel($signed(34'(cfg_i.cruise_duty)) - 34'(u_q),
                                cfg_i.duty_floor, cfg_i.duty_ceil);
    out_d.right_speed   = wheel($signed(34'(cfg_i.cruise_duty)) + 34'(u_q),
                                cfg_i.duty_floor, cfg_i.duty_ceil);
    out_d.control_value = u_q;
    out_d.saturated     = hit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q     <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (go_i && ctrl_i.integ_upd) begin
        integ_q <= integ_d;
      end
      if (go_i && ctrl_i.div_start) begin
        last_q <= err_q;
      end
      if (go_i && ctrl_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i && ctrl_i.take_in) begin
      left_q  <= in_data_i.left_sample;
      right_q <= in_data_i.right_sample;
    end
    if (go_i && ctrl_i.calc_err) begin
      err_q <= err_d;
    end
    if (go_i && ctrl_i.mul_sel != MUL_NONE) begin
      prod_q <= prod_d;
    end
    if (go_i) begin
      acc_q <= acc_d;
      hit_q <= hit_d;
    end
    if (go_i && ctrl_i.sat_u) begin
      u_q <= u_d;
    end
    if (go_i && ctrl_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_busy_o  = out_valid_q && !out_ready_i;

endmodule
`default_nettype wire

// ===== sv/pid_differential_drive_top.sv =====
// Top level of the PID differential-drive steering block: config registers and unit wiring.
//
//   channel  direction  handshake             payload
//   in       input      in_valid/in_ready     in_item_t  (left/right samples)
//   out      output     out_valid/out_ready   out_item_t (wheel duties, u, saturated)
//   cfg      input      cfg_we (no wait)      cfg_idx, cfg_data
//
// Each item runs through the microcode program from transfer in to result ready, with
// four products through one shared 17x33 multiplier and the 2-bit-per-cycle divider
// that forms the derivative. Reset clears the sequencer, the integral and the last
// error and returns the config registers to their defaults. A new input is taken
// only at the first step; an untaken result stalls the last step.
`default_nettype none
module pid_differential_drive_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire pdd_pkg::in_item_t              in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output pdd_pkg::out_item_t                  out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [pdd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [pdd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pdd_pkg::*;

  cfg_t               cfg_q;
  ctrl_t              ctrl;
  logic               go;
  status_t            status;
  logic signed [16:0] div_dividend;
  logic signed [16:0] div_quot;
  logic [15:0]        period;
  logic               div_busy;
  logic               out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reference     <= '0;
      cfg_q.kp            <= '0;
      cfg_q.ki            <= '0;
      cfg_q.kd            <= '0;
      cfg_q.sample_period <= 16'd1;
      cfg_q.cruise_duty   <= '0;
      cfg_q.duty_floor    <= '0;
      cfg_q.duty_ceil     <= 16'hffff;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_REFERENCE:  cfg_q.reference     <= cfg_data_i[11:0];
        REG_KP:         cfg_q.kp            <= cfg_data_i;
        REG_KI:         cfg_q.ki            <= cfg_data_i;
        REG_KD:         cfg_q.kd            <= cfg_data_i;
        REG_PERIOD:     cfg_q.sample_period <= cfg_data_i;
        REG_CRUISE:     cfg_q.cruise_duty   <= cfg_data_i;
        REG_DUTY_FLOOR: cfg_q.duty_floor    <= cfg_data_i;
        REG_DUTY_CEIL:  cfg_q.duty_ceil     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign status.in_valid = in_valid_i;
  assign status.div_busy = div_busy;
  assign status.out_busy = out_busy;

  pdd_ucode u_ucode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl),
    .go_o     (go)
  );

  pdd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (go && ctrl.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (period),
    .quot_o     (div_quot),
    .busy_o     (div_busy)
  );

  pdd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .go_i           (go),
    .cfg_i          (cfg_q),
    .in_data_i      (in_data_i),
    .out_ready_i    (out_ready_i),
    .div_quot_i     (div_quot),
    .div_dividend_o (div_dividend),
    .period_o       (period),
    .out_valid_o    (out_valid_o),
    .out_data_o     (out_data_o),
    .out_busy_o     (out_busy)
  );

  assign in_ready_o = ctrl.take_in;

endmodule
`default_nettype wire
